>>> hw/rtl/track_confirm_color_smoother_unit_assert.svh
// Assertion macros shared by the smoother RTL.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef TRACK_CONFIRM_COLOR_SMOOTHER_UNIT_ASSERT_SVH
`define TRACK_CONFIRM_COLOR_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TCCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

	// Table size. It must be a power of two no larger than 256, so that the
	// slot index is the low bits of the slot field.
	localparam int TRACK_SLOTS = 256;
	localparam int SLOT_W      = $clog2(TRACK_SLOTS);

	localparam int SLOT_FIELD_W = 8;
	localparam int COLOR_W      = 3;
	localparam int COUNT_W      = 9;
	localparam int MIN_W        = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	// Step of the clearing pass, and last slot address.
	localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TRACK_SLOTS - 1);

	// Colour codes.
	localparam logic [COLOR_W-1:0] COL_RED    = 3'd0;
	localparam logic [COLOR_W-1:0] COL_YELLOW = 3'd1;
	localparam logic [COLOR_W-1:0] COL_GREEN  = 3'd2;
	localparam logic [COLOR_W-1:0] COL_BLACK  = 3'd3;

	localparam logic [MIN_W-1:0] MIN_SIGHTINGS_RESET = 8'd3;

	// Per-slot flags, kept in the slot memory beside count and colour.
	typedef struct packed {
		logic seen;
		logic hist;
	} flags_t;

	// One entry of the slot memory.
	typedef struct packed {
		flags_t             flags;
		logic [COUNT_W-1:0] count;
		logic [COLOR_W-1:0] color;
	} word_t;

	// Outcome of one update.
	typedef struct packed {
		logic               keep;
		logic [COLOR_W-1:0] color_out;
		word_t              word;
	} upd_t;

endpackage

>>> hw/rtl/track_confirm_color_smoother_unit.sv
`timescale 1ns / 1ps

// Sighting filter and colour smoother for tracked light detections. Each
// item carries a track slot and a colour and gives exactly one result: the
// slot, a keep flag and the revised colour. After reset the block runs a
// clearing pass that zeroes every slot of the slot memory; s_tready stays
// low until it ends. From then on the block accepts one item per clock while
// results are taken. Stage one waits for the registered read of the slot
// memory; stage two writes the updated word back and loads the result
// register. That result register lets a new item enter while an earlier
// result waits. Items for the same slot back to back are served from a
// register of the last write. The seen and history flags sit in the memory
// word beside the count and the stored colour.
// min_sightings resets to 3 and should only be written while the block is idle.
`include "track_confirm_color_smoother_unit_assert.svh"

module track_confirm_color_smoother_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: min_sightings
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] track_slot, [10:8] color_in, rest zero
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] slot_out, [10:8] color_out, rest zero
	output logic [0:0]  m_tuser    // [0] keep
);

	logic [tccs_pkg::MIN_W-1:0] min_q;

	logic                                  s1_valid_q;
	logic [tccs_pkg::SLOT_FIELD_W-1:0]     slot_s1;
	logic [tccs_pkg::COLOR_W-1:0]          color_s1;
	logic [tccs_pkg::SLOT_W-1:0]           addr_s1;

	logic                                  out_valid_q;
	logic [tccs_pkg::SLOT_FIELD_W-1:0]     slot_s2;
	logic [tccs_pkg::COLOR_W-1:0]          color_s2;
	logic                                  keep_s2;

	logic                                  lw_valid_q;
	logic [tccs_pkg::SLOT_W-1:0]           lw_addr_q;
	tccs_pkg::word_t                       lw_word_q;

	logic                                  clr_busy;
	logic [tccs_pkg::SLOT_W-1:0]           clr_addr;
	logic                                  mem_wr_en;
	logic [tccs_pkg::SLOT_W-1:0]           mem_wr_addr;
	tccs_pkg::word_t                       mem_wr_data;

	logic                                  in_acc;
	logic                                  adv;
	tccs_pkg::word_t                       rd_word;
	tccs_pkg::word_t                       cur_word;
	tccs_pkg::upd_t                        upd;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign adv       = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready  = !clr_busy && (!s1_valid_q || adv);
	assign in_acc    = s_tvalid && s_tready;
	assign addr_s1   = slot_s1[tccs_pkg::SLOT_W-1:0];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= tccs_pkg::MIN_SIGHTINGS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_q <= cfg_data;
		end
	end

	// Stage one: item waits for its memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_s1  <= s_tdata[7:0];
			color_s1 <= s_tdata[10:8];
		end
	end

	tccs_flags u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// The clearing pass owns the write port until it ends.
	assign mem_wr_en   = clr_busy || adv;
	assign mem_wr_addr = clr_busy ? clr_addr : addr_s1;
	assign mem_wr_data = clr_busy ? '0 : upd.word;

	tccs_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (in_acc),
		.rd_addr (s_tdata[tccs_pkg::SLOT_W-1:0]),
		.rd_data (rd_word)
	);

	// The last write always holds the newest word of its slot, so it
	// overrides a read that may have raced with it.
	assign cur_word = (lw_valid_q && (lw_addr_q == addr_s1)) ? lw_word_q : rd_word;

	tccs_update u_upd (
		.color_in      (color_s1),
		.min_sightings (min_q),
		.word_in       (cur_word),
		.upd           (upd)
	);

	// Last-write register for forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (adv) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lw_addr_q <= addr_s1;
			lw_word_q <= upd.word;
		end
	end

	// Stage two: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s2  <= slot_s1;
			color_s2 <= upd.color_out;
			keep_s2  <= upd.keep;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {5'b0, color_s2, slot_s2};
	assign m_tuser[0] = keep_s2;

	// Checks on the pipeline and the update rules.
	`TCCS_ASSERT_NEXT(a_acc_fills_s1, in_acc, s1_valid_q, "accepted item did not reach stage one")
	`TCCS_ASSERT_NEXT(a_s1_holds, s1_valid_q && !adv, s1_valid_q && $stable(slot_s1), "stage one lost a stalled item")
	`TCCS_ASSERT_NOW(a_first_dropped, adv && !cur_word.flags.seen, !upd.keep, "first sighting was kept")
	`TCCS_ASSERT_NOW(a_drop_colour, adv && !upd.keep, upd.color_out == color_s1, "dropped item changed its colour")
	`TCCS_ASSERT_NOW(a_clear_blocks, clr_busy, !s_tready, "item taken during the clearing pass")

endmodule

>>> hw/rtl/tccs_slot_mem.sv
`timescale 1ns / 1ps

// Slot memory: flags, count and stored colour, one write and one read port,
// registered read data.
module tccs_slot_mem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [tccs_pkg::SLOT_W-1:0] wr_addr,
	input  tccs_pkg::word_t            wr_data,
	input  logic                       rd_en,
	input  logic [tccs_pkg::SLOT_W-1:0] rd_addr,
	output tccs_pkg::word_t            rd_data
);

	tccs_pkg::word_t mem [tccs_pkg::TRACK_SLOTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/tccs_flags.sv
`timescale 1ns / 1ps

// Clearing pass after reset: walks every slot once, one per cycle, so that
// a zero word with the seen and history flags clear is written to each.
module tccs_flags (
	input  logic                        clk,
	input  logic                        arst_n,
	output logic                        busy,
	output logic [tccs_pkg::SLOT_W-1:0] addr
);

	logic                        clr_busy_q;
	logic [tccs_pkg::SLOT_W-1:0] clr_addr_q;

	// Address counter; the pass ends after the last slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + tccs_pkg::SLOT_ONE;
			if (clr_addr_q == tccs_pkg::SLOT_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign busy = clr_busy_q;
	assign addr = clr_addr_q;

endmodule

>>> hw/rtl/tccs_update.sv
`timescale 1ns / 1ps

// Modify step of the read-modify-write: sighting filter and colour rules.
module tccs_update (
	input  logic [tccs_pkg::COLOR_W-1:0] color_in,
	input  logic [tccs_pkg::MIN_W-1:0]   min_sightings,
	input  tccs_pkg::word_t              word_in,
	output tccs_pkg::upd_t               upd
);

	logic [tccs_pkg::COUNT_W-1:0] count_nx;
	logic                         keep;
	logic                         is_rgy;

	// Saturating sighting count; a first sighting restarts it at one.
	always_comb begin
		if (!word_in.flags.seen) begin
			count_nx = tccs_pkg::COUNT_ONE;
			keep     = 1'b0;
		end else begin
			if (word_in.count == tccs_pkg::COUNT_MAX) begin
				count_nx = word_in.count;
			end else begin
				count_nx = word_in.count + tccs_pkg::COUNT_ONE;
			end
			keep = count_nx > {1'b0, min_sightings};
		end
	end

	assign is_rgy = (color_in == tccs_pkg::COL_RED) || (color_in == tccs_pkg::COL_YELLOW) ||
		(color_in == tccs_pkg::COL_GREEN);

	// Colour smoothing for kept items.
	always_comb begin
		upd.keep            = keep;
		upd.color_out       = color_in;
		upd.word.flags.seen = 1'b1;
		upd.word.flags.hist = word_in.flags.hist;
		upd.word.count      = count_nx;
		upd.word.color      = word_in.color;
		if (keep) begin
			if (!word_in.flags.hist) begin
				upd.word.flags.hist = 1'b1;
				upd.word.color      = color_in;
			end else if (is_rgy) begin
				// Yellow straight after red is still treated as red.
				if ((color_in == tccs_pkg::COL_YELLOW) &&
					(word_in.color == tccs_pkg::COL_RED)) begin
					upd.color_out = tccs_pkg::COL_RED;
				end
				upd.word.color = upd.color_out;
			end else if (color_in == tccs_pkg::COL_BLACK) begin
				upd.color_out = word_in.color;
			end
		end
	end

endmodule
